// ===== rtl/core/separable_box_blur_defines.svh =====
// Assertion macros for the separable box blur block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SEPARABLE_BOX_BLUR_DEFINES_SVH
`define SEPARABLE_BOX_BLUR_DEFINES_SVH

// Same-cycle implication under reset.
`define SBB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define SBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sbb_pkg.sv =====
// Shared constants, codes and sequencer state type for the box blur block.
// No dependencies.
package sbb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 15;

  localparam int PIX_W  = 16;
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 17;
  localparam int DIM_W  = 9;
  localparam int CRD_W  = 8;
  localparam int RAD_W  = 4;
  localparam int WGT_W  = 8;
  localparam int SUM_W  = 26;
  localparam int NUM_W  = 42;
  localparam int AREA_W = 10;
  localparam int OUT_W  = 32;
  localparam int CFG_W  = 9;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_RADIUS = 2'd2;
  localparam logic [CIDX_W-1:0] REG_WEIGHT = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_PDIV_GO   = 10'b00_0000_0010,
    ST_PDIV_WAIT = 10'b00_0000_0100,
    ST_CLIP      = 10'b00_0000_1000,
    ST_BASE      = 10'b00_0001_0000,
    ST_SCAN      = 10'b00_0010_0000,
    ST_MUL       = 10'b00_0100_0000,
    ST_QDIV_GO   = 10'b00_1000_0000,
    ST_QDIV_WAIT = 10'b01_0000_0000,
    ST_OUT       = 10'b10_0000_0000
  } state_t;

endpackage

// ===== rtl/core/sbb_mem.sv =====
// Frame store: one write port, one read port, registered read data.
// Depends on sbb_pkg.
module sbb_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [sbb_pkg::ADDR_W-1:0] wr_addr,
  input  logic [sbb_pkg::PIX_W-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [sbb_pkg::ADDR_W-1:0] rd_addr,
  output logic [sbb_pkg::PIX_W-1:0]  rd_data
);

  logic [sbb_pkg::PIX_W-1:0] mem [(1 << sbb_pkg::ADDR_W)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sbb_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sbb_pkg.
module sbb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sbb_pkg::NUM_W-1:0]  dividend,
  input  logic [sbb_pkg::AREA_W-1:0] divisor,
  output logic                      done,
  output logic [sbb_pkg::NUM_W-1:0]  quotient,
  output logic [sbb_pkg::AREA_W-1:0] remainder
);

  logic [sbb_pkg::NUM_W-1:0]  dvd_r;
  logic [sbb_pkg::AREA_W-1:0] dsr_r;
  logic [sbb_pkg::AREA_W-1:0] rem_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [sbb_pkg::AREA_W:0]   rem_sh;
  logic                       ge;
  logic [sbb_pkg::AREA_W:0]   rem_new;

  assign rem_sh  = {rem_r, dvd_r[sbb_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_new = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(sbb_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[sbb_pkg::NUM_W-2:0], ge};
      rem_r <= rem_new[sbb_pkg::AREA_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/separable_box_blur.sv =====
// Top level of the separable box blur: frame store, sequencer, divider.
// Depends on sbb_pkg, sbb_mem, sbb_div and separable_box_blur_defines.svh.
//
// Channel | Dir | Handshake        | Content
// in_     | in  | tvalid/tready    | tuser: kind, tdata: pixel
// out_    | out | tvalid/tready    | tdata: blurred, tlast: end of frame
// cfg_    | in  | we               | addr: register index, wdata: value
//
// A load item gives no result.
// A read item on a full frame does one store read per clipped window pixel, plus
// two passes of the 42-step divider (position split, then average).
// Reset (rst_n low, synchronous) clears counters and full flag; store is not cleared.
// Output is registered: the next item is taken while a result waits on out_.
`include "separable_box_blur_defines.svh"

module separable_box_blur (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] blurred
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);

  // configuration
  logic [sbb_pkg::DIM_W-1:0] cfg_width_r, cfg_height_r;
  logic [sbb_pkg::RAD_W-1:0] cfg_radius_r;
  logic [sbb_pkg::WGT_W-1:0] cfg_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 9'd256;
      cfg_height_r <= 9'd256;
      cfg_radius_r <= 4'd1;
      cfg_weight_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbb_pkg::REG_WIDTH:  cfg_width_r  <= cfg_wdata;
        sbb_pkg::REG_HEIGHT: cfg_height_r <= cfg_wdata;
        sbb_pkg::REG_RADIUS: cfg_radius_r <= cfg_wdata[sbb_pkg::RAD_W-1:0];
        sbb_pkg::REG_WEIGHT: cfg_weight_r <= cfg_wdata[sbb_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize saturates
  logic [sbb_pkg::DIM_W-1:0] w_used, h_used, rad;
  logic [sbb_pkg::CNT_W-1:0] total;

  assign w_used = (cfg_width_r == '0) ? 9'd1 :
                  (cfg_width_r > 9'(sbb_pkg::MAX_WIDTH)) ? 9'(sbb_pkg::MAX_WIDTH) : cfg_width_r;
  assign h_used = (cfg_height_r == '0) ? 9'd1 :
                  (cfg_height_r > 9'(sbb_pkg::MAX_HEIGHT)) ? 9'(sbb_pkg::MAX_HEIGHT)
                                                          : cfg_height_r;
  assign rad    = (9'(cfg_radius_r) > 9'(sbb_pkg::MAX_RADIUS)) ? 9'(sbb_pkg::MAX_RADIUS)
                                                              : 9'(cfg_radius_r);
  assign total  = 17'(w_used) * 17'(h_used);

  // sequencer state
  sbb_pkg::state_t state_r, state_nxt;

  logic [sbb_pkg::CNT_W-1:0]  load_cnt_r, read_cnt_r, pos_r;
  logic                       full_r, last_r;
  logic [sbb_pkg::CRD_W-1:0]  x0_r, x1_r, y0_r, y1_r, xx_r, yy_r;
  logic [sbb_pkg::ADDR_W-1:0] row_base_r;
  logic                       issue_done_r, mem_rvld_r;
  logic [sbb_pkg::SUM_W-1:0]  sum_r;
  logic [15:0]                ww_r;
  logic [sbb_pkg::AREA_W-1:0] area_r;
  logic [sbb_pkg::NUM_W-1:0]  num_r;
  logic                       out_valid_r, out_last_r;
  logic [sbb_pkg::OUT_W-1:0]  out_data_r;

  logic                       in_fire, full_eff, out_load;
  logic [sbb_pkg::CNT_W-1:0]  lc, lc_n, pos, pos1;

  // store and divider hookup
  logic                       mem_we, mem_re;
  logic [sbb_pkg::ADDR_W-1:0] mem_raddr;
  logic [sbb_pkg::PIX_W-1:0]  mem_rdata;
  logic                       div_start, div_done;
  logic [sbb_pkg::NUM_W-1:0]  div_dvd, div_quo;
  logic [sbb_pkg::AREA_W-1:0] div_dsr, div_rem;

  // clip helpers
  logic [sbb_pkg::DIM_W-1:0]  px, py, xs, ys;
  logic [5:0]                 dx, dy;

  assign in_tready = (state_r == sbb_pkg::ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign full_eff  = full_r | (load_cnt_r >= total);

  // a load after a full frame restarts the frame
  assign lc   = full_r ? '0 : load_cnt_r;
  assign lc_n = lc + 17'(!lc[sbb_pkg::CNT_W-1]);
  assign pos  = (read_cnt_r >= total) ? '0 : read_cnt_r;
  assign pos1 = pos + 17'd1;

  assign mem_we    = in_fire && (in_tuser == sbb_pkg::KIND_LOAD) && !lc[sbb_pkg::CNT_W-1];
  assign mem_re    = (state_r == sbb_pkg::ST_SCAN) && !issue_done_r;
  assign mem_raddr = row_base_r + 16'(xx_r);

  sbb_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (lc[sbb_pkg::ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // divider: first splits position into row/column, then forms the average
  assign div_start = (state_r == sbb_pkg::ST_PDIV_GO) || (state_r == sbb_pkg::ST_QDIV_GO);
  assign div_dvd   = (state_r == sbb_pkg::ST_PDIV_GO) ? 42'(pos_r) : num_r;
  assign div_dsr   = (state_r == sbb_pkg::ST_PDIV_GO) ? 10'(w_used) : area_r;

  sbb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign px = 9'(div_rem[sbb_pkg::CRD_W-1:0]);
  assign py = 9'(div_quo[sbb_pkg::CRD_W-1:0]);
  assign xs = px + rad;
  assign ys = py + rad;
  assign dx = 6'(x1_r - x0_r) + 6'd1;
  assign dy = 6'(y1_r - y0_r) + 6'd1;

  assign out_load = (state_r == sbb_pkg::ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbb_pkg::ST_IDLE:
        if (in_fire && (in_tuser == sbb_pkg::KIND_READ) && full_eff) begin
          state_nxt = sbb_pkg::ST_PDIV_GO;
        end
      sbb_pkg::ST_PDIV_GO:   state_nxt = sbb_pkg::ST_PDIV_WAIT;
      sbb_pkg::ST_PDIV_WAIT: if (div_done) state_nxt = sbb_pkg::ST_CLIP;
      sbb_pkg::ST_CLIP:      state_nxt = sbb_pkg::ST_BASE;
      sbb_pkg::ST_BASE:      state_nxt = sbb_pkg::ST_SCAN;
      sbb_pkg::ST_SCAN:      if (issue_done_r && !mem_rvld_r) state_nxt = sbb_pkg::ST_MUL;
      sbb_pkg::ST_MUL:       state_nxt = sbb_pkg::ST_QDIV_GO;
      sbb_pkg::ST_QDIV_GO:   state_nxt = sbb_pkg::ST_QDIV_WAIT;
      sbb_pkg::ST_QDIV_WAIT: if (div_done) state_nxt = sbb_pkg::ST_OUT;
      sbb_pkg::ST_OUT:       if (out_load) state_nxt = sbb_pkg::ST_IDLE;
      default:               state_nxt = sbb_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sbb_pkg::ST_IDLE;
      load_cnt_r   <= '0;
      read_cnt_r   <= '0;
      full_r       <= 1'b0;
      issue_done_r <= 1'b0;
      mem_rvld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mem_rvld_r <= mem_re;
      if (in_fire) begin
        if (in_tuser == sbb_pkg::KIND_LOAD) begin
          if (full_r) read_cnt_r <= '0;
          load_cnt_r <= lc_n;
          full_r     <= (lc_n >= total);
        end else if (full_eff) begin
          full_r     <= 1'b1;
          read_cnt_r <= (pos1 >= total) ? '0 : pos1;
        end
      end
      if (state_r == sbb_pkg::ST_BASE) begin
        issue_done_r <= 1'b0;
      end else if (mem_re && (xx_r == x1_r) && (yy_r == y1_r)) begin
        issue_done_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser == sbb_pkg::KIND_READ)) begin
      pos_r  <= pos;
      last_r <= (pos1 == total);
    end
    if (state_r == sbb_pkg::ST_CLIP) begin
      x0_r <= (px >= rad) ? 8'(px - rad) : '0;
      y0_r <= (py >= rad) ? 8'(py - rad) : '0;
      x1_r <= (xs < w_used) ? 8'(xs) : 8'(w_used - 9'd1);
      y1_r <= (ys < h_used) ? 8'(ys) : 8'(h_used - 9'd1);
    end
    if (state_r == sbb_pkg::ST_BASE) begin
      row_base_r <= 16'(17'(y0_r) * 17'(w_used));
      xx_r       <= x0_r;
      yy_r       <= y0_r;
      sum_r      <= '0;
      ww_r       <= 16'(cfg_weight_r) * 16'(cfg_weight_r);
      area_r     <= 10'(12'(dx) * 12'(dy));
    end
    // raster walk over the clipped window, one store read a cycle
    if (mem_re) begin
      if (xx_r == x1_r) begin
        xx_r       <= x0_r;
        yy_r       <= yy_r + 8'd1;
        row_base_r <= row_base_r + 16'(w_used);
      end else begin
        xx_r <= xx_r + 8'd1;
      end
    end
    if (mem_rvld_r) begin
      sum_r <= sum_r + 26'(mem_rdata);
    end
    if (state_r == sbb_pkg::ST_MUL) begin
      num_r <= 42'(ww_r) * 42'(sum_r);
    end
    if (out_load) begin
      out_data_r <= div_quo[sbb_pkg::OUT_W-1:0];
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `SBB_ASSERT_SAME(a_div_done_waiting, clk, rst_n, div_done, (state_r == sbb_pkg::ST_PDIV_WAIT) || (state_r == sbb_pkg::ST_QDIV_WAIT), "divider finished outside a wait state")
  `SBB_ASSERT_NEXT(a_read_starts, clk, rst_n, in_fire && (in_tuser == sbb_pkg::KIND_READ) && full_eff, state_r == sbb_pkg::ST_PDIV_GO, "accepted read on full frame did not start")
  `SBB_ASSERT_NEXT(a_load_counts, clk, rst_n, in_fire && (in_tuser == sbb_pkg::KIND_LOAD), load_cnt_r != '0, "load left the fill count at zero")

endmodule
